### rtl/core/vqdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqdm_pkg
// Types and codes shared by the virtqueue descriptor manager.
// ----------------------------------------------------------------------------
package vqdm_pkg;

  localparam int ADDR_W  = 64;
  localparam int LEN_W   = 32;
  localparam int TOKEN_W = 32;
  localparam int AIDX_W  = 16;
  localparam int ID_W    = 8;
  localparam int FREED_W = 9;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_DESC    = 2'd1,
    STAT_ZERO_TOKEN = 2'd2,
    STAT_NO_TOKEN   = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ADD      = 1'b0,
    CMD_COMPLETE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_CMP_HEAD,
    ST_WALK,
    ST_CMP_END
  } state_t;

  // per-field write enables of the descriptor table
  typedef struct packed {
    logic data;
    logic chained;
    logic link;
  } desc_we_t;

endpackage

### rtl/core/vqdm_desc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqdm_desc_ram
// Descriptor table: one write port with per-field enables, one registered
// read port for the chain flag and link.
// ----------------------------------------------------------------------------
module vqdm_desc_ram
  import vqdm_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int IDX_W = 8
) (
  input  logic                 clk,
  input  logic [IDX_W-1:0]     wr_addr,
  input  desc_we_t             wr_en,
  input  logic [ADDR_W-1:0]    wr_address,
  input  logic [LEN_W-1:0]     wr_length,
  input  logic                 wr_writable,
  input  logic                 wr_chained,
  input  logic [IDX_W-1:0]     wr_link,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic                 rd_chained,
  output logic [IDX_W-1:0]     rd_link
);

  logic [ADDR_W-1:0] address_mem  [DEPTH];
  logic [LEN_W-1:0]  length_mem   [DEPTH];
  logic              writable_mem [DEPTH];
  logic              chained_mem  [DEPTH];
  logic [IDX_W-1:0]  link_mem     [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en.data) begin
      address_mem[wr_addr]  <= wr_address;
      length_mem[wr_addr]   <= wr_length;
      writable_mem[wr_addr] <= wr_writable;
    end
    if (wr_en.chained) begin
      chained_mem[wr_addr] <= wr_chained;
    end
    if (wr_en.link) begin
      link_mem[wr_addr] <= wr_link;
    end
    rd_chained <= chained_mem[rd_addr];
    rd_link    <= link_mem[rd_addr];
  end

endmodule

### rtl/core/virtqueue_descriptor_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtqueue_descriptor_manager
// Driver side of one split virtqueue: descriptor free list, chain add and
// used-element completion. One item at a time.
// An add item answers from ST_ADD. A completion item reads the head token in
// ST_CMP_HEAD, walks the chain in ST_WALK, one table read per descriptor and
// at most QUEUE_SIZE descriptors, and answers from ST_CMP_END; with no stored
// token it answers from ST_CMP_HEAD. Output stalls hold the answering state.
// Reset: a clearing pass over every descriptor rebuilds the free list and
// clears the tokens; in_stall stays high until it ends.
// ----------------------------------------------------------------------------
module virtqueue_descriptor_manager
  import vqdm_pkg::*;
#(
  parameter int QUEUE_SIZE = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [63:0]        buf_addr,
  input  logic [31:0]        buf_len,
  input  logic               buf_writable,
  input  logic               seg_final,
  input  logic [31:0]        token_in,
  input  logic [7:0]         used_id,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic               posted,
  output logic [7:0]         avail_slot,
  output logic [7:0]         avail_head,
  output logic [15:0]        avail_index_new,
  output logic               kick,
  output logic [31:0]        token_out,
  output logic [8:0]         freed_count,
  output logic [7:0]         used_slot
);

  localparam int IW = $clog2(QUEUE_SIZE);
  localparam int CW = $clog2(QUEUE_SIZE + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_SIZE - 1);
  localparam logic [CW-1:0] Q_COUNT  = CW'(QUEUE_SIZE);

  state_t state, state_next;

  logic [IW-1:0]     clr_idx;
  logic [IW-1:0]     fl_head, fl_tail;
  logic [CW-1:0]     free_count;
  logic [AIDX_W-1:0] avail_index;
  logic [IW-1:0]     avail_cursor;
  logic [IW-1:0]     used_cursor;
  logic [IW-1:0]     pending_cursor;
  logic [CW-1:0]     pending_count;
  logic              chain_open;

  logic [ADDR_W-1:0]  cap_addr;
  logic [LEN_W-1:0]   cap_len;
  logic               cap_writable;
  logic               cap_final;
  logic [TOKEN_W-1:0] cap_token;
  logic [IW-1:0]      cap_uslot;

  logic [IW-1:0]      head;
  logic [IW-1:0]      idx;
  logic [CW-1:0]      cnt;
  logic [TOKEN_W-1:0] tok;

  logic [TOKEN_W-1:0] token_mem [QUEUE_SIZE];
  logic [TOKEN_W-1:0] token_rd;

  logic [IW-1:0] id_mod [256];

  genvar g;
  generate
    for (g = 0; g < 256; g++) begin : g_id_mod
      assign id_mod[g] = IW'(g % QUEUE_SIZE);
    end
  endgenerate

  logic              accept, out_free;
  logic              rd_chained;
  logic [IW-1:0]     rd_link;
  logic [IW-1:0]     eff_link;
  logic              walk_more;
  logic              no_desc, zero_tok, add_ok;
  logic [IW-1:0]     open_cursor;
  logic [CW:0]       freed_sum;

  logic [IW-1:0]      rd_addr;
  logic [IW-1:0]      d_waddr;
  desc_we_t           d_we;
  logic               d_wchained;
  logic [IW-1:0]      d_wlink;
  logic               t_we;
  logic [IW-1:0]      t_waddr;
  logic [TOKEN_W-1:0] t_wdata;

  logic              res_load;
  status_t           res_status;
  logic              res_posted;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;

  assign open_cursor = chain_open ? pending_cursor : fl_head;
  assign no_desc     = (pending_count >= free_count);
  assign zero_tok    = cap_final && (cap_token == '0);
  assign add_ok      = !no_desc && !zero_tok;
  assign eff_link    = (idx == fl_tail) ? head : rd_link;
  assign walk_more   = rd_chained && (cnt < Q_COUNT);
  assign freed_sum   = {1'b0, free_count} + {1'b0, cnt};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == LAST_IDX) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_next = (cmd == CMD_COMPLETE) ? ST_CMP_HEAD : ST_ADD;
      end
      ST_ADD: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_CMP_HEAD: begin
        if (token_rd != '0) state_next = ST_WALK;
        else if (out_free) state_next = ST_IDLE;
      end
      ST_WALK: begin
        if (!walk_more) state_next = ST_CMP_END;
      end
      ST_CMP_END: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    rd_addr    = idx;
    d_waddr    = idx;
    d_we       = '0;
    d_wchained = 1'b1;
    d_wlink    = fl_head;
    t_we       = 1'b0;
    t_waddr    = head;
    t_wdata    = '0;
    res_load   = 1'b0;
    res_status = STAT_OK;
    res_posted = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        d_waddr      = clr_idx;
        d_we.link    = 1'b1;
        d_we.chained = 1'b1;
        d_wlink      = (clr_idx == LAST_IDX) ? '0 : clr_idx + 1'b1;
        t_we         = 1'b1;
        t_waddr      = clr_idx;
      end
      ST_IDLE: begin
        rd_addr = (cmd == CMD_COMPLETE) ? id_mod[used_id] : open_cursor;
      end
      ST_ADD: begin
        rd_addr = pending_cursor;
        d_waddr = pending_cursor;
        if (out_free) begin
          res_load = 1'b1;
          if (no_desc) begin
            res_status = STAT_NO_DESC;
          end else if (zero_tok) begin
            res_status = STAT_ZERO_TOKEN;
          end else begin
            d_we.data    = 1'b1;
            d_we.chained = 1'b1;
            d_wchained   = !cap_final;
            if (cap_final) begin
              res_posted = 1'b1;
              t_we       = 1'b1;
              t_waddr    = fl_head;
              t_wdata    = cap_token;
            end
          end
        end
      end
      ST_CMP_HEAD: begin
        rd_addr = head;
        d_waddr = fl_tail;
        d_wlink = head;
        if (token_rd != '0) begin
          d_we.link = 1'b1;
        end else if (out_free) begin
          res_load   = 1'b1;
          res_status = STAT_NO_TOKEN;
        end
      end
      ST_WALK: begin
        rd_addr = walk_more ? eff_link : idx;
      end
      ST_CMP_END: begin
        if (out_free) begin
          res_load     = 1'b1;
          d_we.link    = 1'b1;
          d_we.chained = 1'b1;
          t_we         = 1'b1;
        end
      end
      default: ;
    endcase
  end

  vqdm_desc_ram #(
    .DEPTH (QUEUE_SIZE),
    .IDX_W (IW)
  ) u_desc_ram (
    .clk         (clk),
    .wr_addr     (d_waddr),
    .wr_en       (d_we),
    .wr_address  (cap_addr),
    .wr_length   (cap_len),
    .wr_writable (cap_writable),
    .wr_chained  (d_wchained),
    .wr_link     (d_wlink),
    .rd_addr     (rd_addr),
    .rd_chained  (rd_chained),
    .rd_link     (rd_link)
  );

  always_ff @(posedge clk) begin
    if (t_we) token_mem[t_waddr] <= t_wdata;
    token_rd <= token_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_idx        <= '0;
      fl_head        <= '0;
      fl_tail        <= LAST_IDX;
      free_count     <= Q_COUNT;
      avail_index    <= '0;
      avail_cursor   <= '0;
      used_cursor    <= '0;
      pending_cursor <= '0;
      pending_count  <= '0;
      chain_open     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_idx <= clr_idx + 1'b1;

      if (res_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      if (accept && cmd == CMD_ADD) begin
        chain_open     <= 1'b1;
        pending_cursor <= open_cursor;
        if (!chain_open) pending_count <= '0;
      end

      if (accept && cmd == CMD_COMPLETE) begin
        used_cursor <= (used_cursor == LAST_IDX) ? '0 : used_cursor + 1'b1;
      end

      if (state == ST_ADD && out_free) begin
        if (!add_ok) begin
          chain_open    <= 1'b0;
          pending_count <= '0;
        end else begin
          pending_cursor <= rd_link;
          if (cap_final) begin
            fl_head       <= rd_link;
            free_count    <= free_count - (pending_count + 1'b1);
            avail_index   <= avail_index + 1'b1;
            if (avail_index == '1 || avail_cursor == LAST_IDX) avail_cursor <= '0;
            else avail_cursor <= avail_cursor + 1'b1;
            chain_open    <= 1'b0;
            pending_count <= '0;
          end else begin
            pending_count <= pending_count + 1'b1;
          end
        end
      end

      if (state == ST_CMP_END && out_free) begin
        fl_tail    <= idx;
        free_count <= (freed_sum > {1'b0, Q_COUNT}) ? Q_COUNT : freed_sum[CW-1:0];
      end
    end
  end

  // item capture and walk registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cap_addr     <= buf_addr;
      cap_len      <= buf_len;
      cap_writable <= buf_writable;
      cap_final    <= seg_final;
      cap_token    <= token_in;
      cap_uslot    <= used_cursor;
      head         <= id_mod[used_id];
    end
    if (state == ST_CMP_HEAD) begin
      tok <= token_rd;
      idx <= head;
      cnt <= CW'(1);
    end else if (state == ST_WALK && walk_more) begin
      idx <= eff_link;
      cnt <= cnt + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      status          <= res_status;
      posted          <= res_posted;
      kick            <= res_posted;
      avail_slot      <= res_posted ? 8'(avail_cursor) : '0;
      avail_head      <= res_posted ? 8'(fl_head) : '0;
      avail_index_new <= res_posted ? avail_index + 1'b1 : '0;
      token_out       <= (state == ST_CMP_END) ? tok : '0;
      freed_count     <= (state == ST_CMP_END) ? 9'(cnt) : '0;
      used_slot       <= (state == ST_ADD) ? '0 : 8'(cap_uslot);
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - virtqueue descriptor manager testbench
// Drives add and completion items through the valid/stall handshake, keeps
// a behavioral copy of the free list, token store and ring cursors, and
// checks every result field in order. Covers segment extremes, zero-token
// and out-of-descriptor drops, completions inside an open chain, a full
// queue with exhaustion and the corrupted lists that follow, and random
// traffic with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  import vqdm_pkg::*;

  localparam int QSIZE       = 256;
  localparam int TOTAL_ITEMS = 1050;

  typedef struct packed {
    cmd_t        op;
    logic [63:0] addr;
    logic [31:0] len;
    logic        wr;
    logic        fin;
    logic [31:0] tok;
    logic [7:0]  id;
  } vq_item_t;

  typedef struct packed {
    status_t     status;
    logic        posted;
    logic [7:0]  avail_slot;
    logic [7:0]  avail_head;
    logic [15:0] avail_index_new;
    logic        kick;
    logic [31:0] token_out;
    logic [8:0]  freed_count;
    logic [7:0]  used_slot;
  } vq_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        cmd;
  logic [63:0] buf_addr;
  logic [31:0] buf_len;
  logic        buf_writable;
  logic        seg_final;
  logic [31:0] token_in;
  logic [7:0]  used_id;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic        posted;
  logic [7:0]  avail_slot;
  logic [7:0]  avail_head;
  logic [15:0] avail_index_new;
  logic        kick;
  logic [31:0] token_out;
  logic [8:0]  freed_count;
  logic [7:0]  used_slot;

  virtqueue_descriptor_manager #(.QUEUE_SIZE(QSIZE)) u_dut (.*);

  // shadow of the queue state
  logic        sh_chained [QSIZE];
  logic [7:0]  sh_link    [QSIZE];
  logic [31:0] sh_token   [QSIZE];
  logic [7:0]  fl_head, fl_tail, used_cursor, pend_cursor;
  logic [15:0] avail_idx;
  int          free_count, pend_count;
  bit          chain_open;

  vq_result_t  expect_q[$];
  logic [7:0]  live_heads[$];
  bit          calm;
  int          n_items, n_bad;
  int          n_posted, n_returned, n_dropped, n_empty, longest_walk;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(15_000_000);
    $display("timeout with %0d results outstanding", expect_q.size());
    $display("virtqueue_descriptor_manager: mismatch");
    $finish;
  end

  function automatic void shadow_reset();
    for (int i = 0; i < QSIZE; i++) begin
      sh_chained[i] = 1'b1;
      sh_link[i]    = 8'(i + 1);
      sh_token[i]   = '0;
    end
    fl_head     = '0;
    fl_tail     = 8'(QSIZE - 1);
    free_count  = QSIZE;
    avail_idx   = '0;
    used_cursor = '0;
    pend_cursor = '0;
    pend_count  = 0;
    chain_open  = 1'b0;
  endfunction

  function automatic vq_result_t queue_step(vq_item_t it);
    vq_result_t r;
    logic [7:0] slot, head, idx;
    logic [31:0] tok;
    int cnt;
    r = '0;
    if (it.op == CMD_ADD) begin
      if (!chain_open) begin
        chain_open  = 1'b1;
        pend_cursor = fl_head;
        pend_count  = 0;
      end
      if (pend_count >= free_count) begin
        chain_open = 1'b0;
        pend_count = 0;
        r.status   = STAT_NO_DESC;
        return r;
      end
      if (it.fin && it.tok == '0) begin
        chain_open = 1'b0;
        pend_count = 0;
        r.status   = STAT_ZERO_TOKEN;
        return r;
      end
      slot             = pend_cursor;
      sh_chained[slot] = 1'b1;
      pend_cursor      = sh_link[slot];
      pend_count++;
      if (it.fin) begin
        sh_chained[slot] = 1'b0;
        head             = fl_head;
        fl_head          = pend_cursor;
        free_count      -= pend_count;
        sh_token[head]   = it.tok;
        r.posted         = 1'b1;
        r.avail_slot     = avail_idx[7:0];
        r.avail_head     = head;
        avail_idx++;
        r.avail_index_new = avail_idx;
        r.kick           = 1'b1;
        chain_open       = 1'b0;
        pend_count       = 0;
        live_heads.push_back(head);
      end
    end else begin
      head = it.id;
      idx  = head;
      cnt  = 1;
      tok  = sh_token[head];
      r.used_slot = used_cursor;
      used_cursor++;
      for (int i = 0; i < live_heads.size(); i++) begin
        if (live_heads[i] == head) begin
          live_heads.delete(i);
          break;
        end
      end
      if (tok == '0) begin
        r.status = STAT_NO_TOKEN;
      end else begin
        sh_link[fl_tail] = head;
        while (sh_chained[idx] && cnt < QSIZE) begin
          idx = sh_link[idx];
          cnt++;
        end
        fl_tail         = idx;
        sh_link[idx]    = fl_head;
        sh_chained[idx] = 1'b1;
        free_count     += cnt;
        if (free_count > QSIZE) free_count = QSIZE;
        sh_token[head]  = '0;
        r.token_out     = tok;
        r.freed_count   = 9'(cnt);
      end
    end
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] nz_token();
    logic [31:0] t;
    t = $urandom;
    return (t == '0) ? 32'd1 : t;
  endfunction

  function automatic int chain_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
  endfunction

  function automatic string fmt_result(vq_result_t r);
    return {$sformatf("st=%s posted=%0b aslot=%0d ahead=%0d aidx=%0d kick=%0b ",
                      r.status.name(), r.posted, r.avail_slot, r.avail_head,
                      r.avail_index_new, r.kick),
            $sformatf("tok=%h freed=%0d uslot=%0d",
                      r.token_out, r.freed_count, r.used_slot)};
  endfunction

  // send one item; returns at the accepting edge or after the following gap
  task automatic push_item(input vq_item_t it);
    vq_result_t r;
    int gap;
    cmd          <= it.op;
    buf_addr     <= it.addr;
    buf_len      <= it.len;
    buf_writable <= it.wr;
    seg_final    <= it.fin;
    token_in     <= it.tok;
    used_id      <= it.id;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    r = queue_step(it);
    expect_q.push_back(r);
    n_items++;
    case (r.status)
      STAT_OK: begin
        if (r.posted) n_posted++;
        if (it.op == CMD_COMPLETE) n_returned++;
        if (int'(r.freed_count) > longest_walk) longest_walk = int'(r.freed_count);
      end
      STAT_NO_TOKEN: n_empty++;
      default: n_dropped++;
    endcase
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_add(logic [63:0] addr, logic [31:0] len, logic wr, logic fin,
                          logic [31:0] tok);
    vq_item_t it;
    it.op   = CMD_ADD;
    it.addr = addr;
    it.len  = len;
    it.wr   = wr;
    it.fin  = fin;
    it.tok  = tok;
    it.id   = 8'($urandom);
    push_item(it);
  endtask

  task automatic add_seg(logic fin, logic [31:0] tok);
    send_add({$urandom, $urandom}, $urandom, 1'($urandom_range(0, 1)), fin, tok);
  endtask

  task automatic send_cmp(logic [7:0] id);
    vq_item_t it;
    it.op   = CMD_COMPLETE;
    it.addr = {$urandom, $urandom};
    it.len  = $urandom;
    it.wr   = 1'($urandom_range(0, 1));
    it.fin  = 1'($urandom_range(0, 1));
    it.tok  = $urandom;
    it.id   = id;
    push_item(it);
  endtask

  task automatic add_chain(int nseg, logic [31:0] tok);
    for (int i = 0; i < nseg - 1; i++) add_seg(1'b0, $urandom);
    add_seg(1'b1, tok);
  endtask

  task automatic complete_live();
    if (live_heads.size() == 0) return;
    send_cmp(live_heads[$urandom_range(0, live_heads.size() - 1)]);
  endtask

  task automatic complete_all_live();
    while (live_heads.size() != 0) begin
      if ($urandom_range(0, 9) == 0) send_cmp(8'($urandom));
      complete_live();
    end
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expect_q.size() != 0);
  endtask

  task automatic test_segment_extremes();
    send_add('0, '0, 1'b0, 1'b1, 32'd1);
    send_add('1, '1, 1'b1, 1'b1, '1);
  endtask

  // tokens on non-final segments are ignored, zero included
  task automatic test_multi_segment_chain();
    add_seg(1'b0, '0);
    add_seg(1'b0, '0);
    add_seg(1'b1, 32'h8000_0001);
  endtask

  task automatic test_completions();
    send_cmp(8'd1);
    send_cmp(8'd1);
    send_cmp(8'd255);
    send_cmp(8'd0);
  endtask

  task automatic test_zero_token();
    add_seg(1'b0, nz_token());
    add_seg(1'b1, '0);
    add_seg(1'b1, '0);
  endtask

  task automatic test_completion_in_open_chain();
    add_seg(1'b0, $urandom);
    add_seg(1'b0, $urandom);
    complete_live();
    add_seg(1'b1, nz_token());
    complete_all_live();
  endtask

  // fill the table exactly, overrun it, then overrun again with one long chain
  task automatic test_fill_and_exhaust();
    int len, guard;
    logic fin;
    while (free_count != 0) begin
      len = $urandom_range(16, 64);
      for (int s = 0; s < len; s++) begin
        fin = (s == len - 1) || (pend_count + 1 >= free_count);
        add_seg(fin, nz_token());
        if (fin) break;
      end
    end
    add_seg(1'b1, nz_token());
    complete_all_live();
    guard = 0;
    add_seg(1'b0, $urandom);
    while (chain_open && guard < 300) begin
      add_seg(1'b0, $urandom);
      guard++;
    end
    add_chain(3, nz_token());
    complete_all_live();
  endtask

  task automatic test_random_traffic();
    int r;
    hold_until_drained();
    while (n_items < TOTAL_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 40 && live_heads.size() < 24) begin
        add_chain(chain_len(), nz_token());
      end else if (r < 78) begin
        if (live_heads.size() != 0) complete_live();
        else add_chain(chain_len(), nz_token());
      end else if (r < 84) begin
        send_cmp(8'($urandom));
      end else if (r < 90) begin
        repeat ($urandom_range(0, 2)) add_seg(1'b0, $urandom);
        add_seg(1'b1, '0);
      end else if (r < 94) begin
        add_seg(1'b0, $urandom);
        if (live_heads.size() != 0) complete_live();
        else send_cmp(8'($urandom));
        add_seg(1'b1, nz_token());
      end else if (r < 96) begin
        hold_until_drained();
      end else begin
        calm = !calm;
      end
    end
    calm = 1'b0;
  endtask

  initial begin : out_stall_gen
    int run;
    out_stall <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 12)) @(posedge clk);
      run = idle_len();
      if (run != 0) begin
        out_stall <= 1'b1;
        repeat (run) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    vq_result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got.status          = status_t'(status);
      got.posted          = posted;
      got.avail_slot      = avail_slot;
      got.avail_head      = avail_head;
      got.avail_index_new = avail_index_new;
      got.kick            = kick;
      got.token_out       = token_out;
      got.freed_count     = freed_count;
      got.used_slot       = used_slot;
      if (expect_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result: %s", fmt_result(got));
      end else begin
        want = expect_q.pop_front();
        if (got !== want) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(got));
          end
        end
      end
    end
  end

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    cmd          <= CMD_ADD;
    buf_addr     <= '0;
    buf_len      <= '0;
    buf_writable <= 1'b0;
    seg_final    <= 1'b0;
    token_in     <= '0;
    used_id      <= '0;
    calm         = 1'b0;
    n_items      = 0;
    n_bad        = 0;
    n_posted     = 0;
    n_returned   = 0;
    n_dropped    = 0;
    n_empty      = 0;
    longest_walk = 0;
    shadow_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_segment_extremes();
    test_multi_segment_chain();
    test_completions();
    test_zero_token();
    test_completion_in_open_chain();
    test_fill_and_exhaust();
    test_random_traffic();

    hold_until_drained();
    repeat (300) @(posedge clk);

    $display("%0d items: %0d chains posted, %0d returned, %0d dropped, %0d empty",
             n_items, n_posted, n_returned, n_dropped, n_empty);
    $display("longest chain walk %0d descriptors, %0d result errors", longest_walk, n_bad);
    if (n_bad == 0 && expect_q.size() == 0) begin
      $display("virtqueue_descriptor_manager: match");
    end else begin
      $display("virtqueue_descriptor_manager: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/vqdm_pkg.sv
rtl/core/vqdm_desc_ram.sv
rtl/core/virtqueue_descriptor_manager.sv
tb/sv/tb.sv
